@@ rtl/swcd_pkg.sv @@
`timescale 1ns / 1ps

package swcd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned LenW    = 31;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] SyncWordRst = 32'h0000_0000;
  localparam logic [LenW-1:0]  MaxLenRst   = 31'd65536;

  // byte order mode register codes; the unused code behaves as automatic
  localparam logic [ModeW-1:0] ModeBig    = 2'd0;
  localparam logic [ModeW-1:0] ModeLittle = 2'd1;
  localparam logic [ModeW-1:0] ModeAuto   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSyncWord  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxLength = 2'd1;
  localparam logic [CfgIdxW-1:0] RegByteOrder = 2'd2;

  localparam logic [CntW-1:0] CntTypeDone = 3'd4;
  localparam logic [CntW-1:0] CntLenDone  = 3'd0;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_HUNT   = 3'd0,
    ST_SYNC   = 3'd1,
    ST_HDR    = 3'd2,
    ST_START  = 3'd3,
    ST_PAY    = 3'd4,
    ST_BADLEN = 3'd5,
    ST_LOST   = 3'd6,
    ST_TRAIL  = 3'd7
  } status_t;

  function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

@@ rtl/swcd_if.sv @@
`timescale 1ns / 1ps

interface swcd_in_if;
  import swcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface swcd_out_if;
  import swcd_pkg::*;
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic signed [WordW-1:0] chunk_type;
  logic [LenW-1:0]     chunk_length;
  logic [ByteW-1:0]    out_byte;
  logic                last_payload;
  logic                big_endian;

  modport source (output valid, output status, output chunk_type, output chunk_length,
                  output out_byte, output last_payload, output big_endian, input ready);
  modport sink   (input valid, input status, input chunk_type, input chunk_length,
                  input out_byte, input last_payload, input big_endian, output ready);
endinterface

interface swcd_cfg_if;
  import swcd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sync_word_chunk_deframer_core.sv @@
`timescale 1ns / 1ps

// Sync-word chunk deframer.
// in_ch  : one stream byte per word (valid/ready).
// out_ch : one result word per input byte: status, captured chunk type and
//          length, passed-through payload byte with last flag, byte order.
// cfg_ch : register writes (index 0 sync word, 1 max chunk length, 2 byte
//          order mode), always ready; the user must write them only while idle (not enforced).
// Each accepted byte updates the deframer state in the same cycle and its
// result sits in the output register on the next cycle; throughput 1 byte per
// cycle while the receiver takes results, set by the single state update from
// the input byte to the result register.
// If the receiver stalls, the output register holds its word and in_ch.ready
// drops until that word is taken; with out_ch.ready high, a byte can enter
// every cycle while the previous result is delivered.
// Reset (rst_n low, synchronous) returns to hunting with a cleared window,
// big-endian order, zero captured fields, registers at their reset values and
// an empty output register.
module sync_word_chunk_deframer_core
  import swcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  swcd_in_if.sink      in_ch,
  swcd_out_if.source   out_ch,
  swcd_cfg_if.sink     cfg_ch
);

  // configuration
  logic [WordW-1:0] sync_r;
  logic [LenW-1:0]  max_len_r;
  logic [ModeW-1:0] mode_r;

  // deframer state
  phase_t           phase_r, phase_nxt;
  logic [WordW-1:0] win_r, win_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [WordW-1:0] type_r, type_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [LenW-1:0]  rem_r, rem_nxt;
  logic             big_r, big_nxt;

  // result
  status_t          status_nxt;
  logic [ByteW-1:0] obyte_nxt;
  logic             last_nxt;

  logic               out_valid_r;
  logic [StatusW-1:0] out_status_r;
  logic [WordW-1:0]   out_type_r;
  logic [LenW-1:0]    out_len_r;
  logic [ByteW-1:0]   out_byte_r;
  logic               out_last_r;
  logic               out_big_r;

  logic             in_acc;
  logic             cfg_acc;
  logic [WordW-1:0] shifted;
  logic [CntW-1:0]  cnt_inc;
  logic [LenW-1:0]  rem_dec;
  logic             match_big, match_swap;
  logic             auto_mode;
  logic             hunt_sync, hunt_big;
  logic             trail_sync;
  logic             len_bad;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid & cfg_ch.ready;
  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign in_acc       = in_ch.valid & in_ch.ready;

  // hunting always shifts big-endian; header and trailer follow current order
  always_comb begin
    if (phase_r == PH_HUNT || big_r) begin
      shifted = {win_r[WordW-ByteW-1:0], in_ch.in_byte};
    end else begin
      shifted = {in_ch.in_byte, win_r[WordW-1:ByteW]};
    end
  end

  assign cnt_inc    = cnt_r + CntW'(1);
  assign rem_dec    = rem_r - LenW'(1);
  assign match_big  = (shifted == sync_r);
  assign match_swap = (swap32(shifted) == sync_r);
  assign auto_mode  = mode_r[1];
  assign len_bad    = shifted[WordW-1] | (shifted[LenW-1:0] > max_len_r)
                    | (shifted[1:0] != 2'b00);
  assign trail_sync = match_big | (auto_mode & match_swap);

  always_comb begin
    unique case (mode_r)
      ModeBig: begin
        hunt_sync = match_big;
        hunt_big  = 1'b1;
      end
      ModeLittle: begin
        hunt_sync = match_swap;
        hunt_big  = 1'b0;
      end
      default: begin
        hunt_sync = match_big | match_swap;
        hunt_big  = match_big;
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (hunt_sync) phase_nxt = PH_HEADER;
      end
      PH_HEADER: begin
        if (cnt_inc == CntLenDone) begin
          if (len_bad) begin
            phase_nxt = PH_HUNT;
          end else if (shifted == '0) begin
            phase_nxt = PH_TRAILER;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (rem_dec == '0) phase_nxt = PH_TRAILER;
      end
      PH_TRAILER: begin
        if (cnt_inc[CntW-1]) phase_nxt = trail_sync ? PH_HEADER : PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    big_nxt    = big_r;
    status_nxt = ST_HUNT;
    obyte_nxt  = '0;
    last_nxt   = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        win_nxt = shifted;
        if (hunt_sync) begin
          status_nxt = ST_SYNC;
          big_nxt    = hunt_big;
          win_nxt    = '0;
          cnt_nxt    = '0;
        end
      end
      PH_HEADER: begin
        win_nxt = shifted;
        cnt_nxt = cnt_inc;
        if (cnt_inc == CntTypeDone) begin
          type_nxt   = shifted;
          win_nxt    = '0;
          status_nxt = ST_HDR;
        end else if (cnt_inc == CntLenDone) begin
          len_nxt = shifted[LenW-1:0];
          win_nxt = '0;
          if (len_bad) begin
            status_nxt = ST_BADLEN;
            cnt_nxt    = '0;
          end else begin
            status_nxt = ST_START;
            rem_nxt    = shifted[LenW-1:0];
          end
        end else begin
          status_nxt = ST_HDR;
        end
      end
      PH_PAYLOAD: begin
        status_nxt = ST_PAY;
        obyte_nxt  = in_ch.in_byte;
        rem_nxt    = rem_dec;
        if (rem_dec == '0) begin
          last_nxt = 1'b1;
          win_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      PH_TRAILER: begin
        win_nxt = shifted;
        cnt_nxt = cnt_inc;
        if (cnt_inc[CntW-1]) begin
          win_nxt = '0;
          cnt_nxt = '0;
          if (match_big) begin
            status_nxt = ST_SYNC;
          end else if (auto_mode && match_swap) begin
            status_nxt = ST_SYNC;
            big_nxt    = ~big_r;
          end else begin
            status_nxt = ST_LOST;
          end
        end else begin
          status_nxt = ST_TRAIL;
        end
      end
      default: begin
        win_nxt = '0;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= SyncWordRst;
      max_len_r <= MaxLenRst;
      mode_r    <= ModeAuto;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        RegSyncWord:  sync_r    <= cfg_ch.data;
        RegMaxLength: max_len_r <= cfg_ch.data[LenW-1:0];
        RegByteOrder: mode_r    <= cfg_ch.data[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      cnt_r   <= '0;
      type_r  <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      big_r   <= 1'b1;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      big_r   <= big_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_acc | (out_valid_r & ~out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= status_nxt;
      out_type_r   <= type_nxt;
      out_len_r    <= len_nxt;
      out_byte_r   <= obyte_nxt;
      out_last_r   <= last_nxt;
      out_big_r    <= big_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.chunk_type   = out_type_r;
  assign out_ch.chunk_length = out_len_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.last_payload = out_last_r;
  assign out_ch.big_endian   = out_big_r;

endmodule

@@ verif/sync_word_chunk_deframer_core_tb.sv @@
`timescale 1ns / 1ps

module sync_word_chunk_deframer_core_tb;
  import swcd_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int RxHoldCycles  = 300;
  localparam int DrainCycles   = 4;
  localparam int PrintedErrMax = 30;
  // spare mode code, decodes as automatic
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  typedef struct packed {
    status_t            st;
    logic signed [WordW-1:0] ctype;
    logic [LenW-1:0]    clen;
    logic [ByteW-1:0]   obyte;
    logic               last;
    logic               big;
  } deframe_res_t;

  logic clk = 1'b0;
  logic rst_n;

  swcd_in_if  in_ch ();
  swcd_out_if out_ch ();
  swcd_cfg_if cfg_ch ();

  sync_word_chunk_deframer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // deframer state as the block should hold it
  phase_t           df_phase  = PH_HUNT;
  logic [WordW-1:0] df_window = '0;
  logic [CntW-1:0]  df_count  = '0;
  logic [WordW-1:0] df_type   = '0;
  logic [LenW-1:0]  df_length = '0;
  logic [LenW-1:0]  df_left   = '0;
  logic             df_big    = 1'b1;
  logic [WordW-1:0] reg_sync  = SyncWordRst;
  logic [LenW-1:0]  reg_max   = MaxLenRst;
  logic [ModeW-1:0] reg_mode  = ModeAuto;

  // settings as the stimulus side last wrote them
  logic [WordW-1:0] gen_sync = SyncWordRst;
  logic [LenW-1:0]  gen_max  = MaxLenRst;
  logic [ModeW-1:0] gen_mode = ModeAuto;

  deframe_res_t expected_q[$];
  int n_errors   = 0;
  int n_checked  = 0;
  int bytes_sent = 0;
  int seen_status [8];
  int last_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int stall_cycles = 0;

  function automatic logic [WordW-1:0] bytes_reversed(input logic [WordW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [WordW-1:0] window_shift(input logic [WordW-1:0] w,
                                                    input logic [ByteW-1:0] b,
                                                    input logic big);
    return big ? {w[23:0], b} : {b, w[31:8]};
  endfunction

  function automatic deframe_res_t deframe_byte(input logic [ByteW-1:0] b);
    deframe_res_t     r;
    logic [WordW-1:0] len;
    logic             auto_mode;
    r = '0;
    r.st = ST_HUNT;
    auto_mode = (reg_mode != ModeBig) && (reg_mode != ModeLittle);
    case (df_phase)
      PH_HUNT: begin
        df_window = {df_window[23:0], b};
        if (reg_mode != ModeLittle && df_window == reg_sync) begin
          df_big = 1'b1;
          r.st = ST_SYNC;
        end else if (reg_mode != ModeBig && bytes_reversed(df_window) == reg_sync) begin
          df_big = 1'b0;
          r.st = ST_SYNC;
        end
        if (r.st == ST_SYNC) begin
          df_phase = PH_HEADER;
          df_window = '0;
          df_count = '0;
        end
      end
      PH_HEADER: begin
        df_window = window_shift(df_window, b, df_big);
        df_count = df_count + 3'd1;
        if (df_count == CntTypeDone) begin
          df_type = df_window;
          df_window = '0;
          r.st = ST_HDR;
        end else if (df_count == CntLenDone) begin
          len = df_window;
          df_length = len[LenW-1:0];
          if (len[31] || len > {1'b0, reg_max} || len[1:0] != 2'd0) begin
            r.st = ST_BADLEN;
            df_phase = PH_HUNT;
            df_window = '0;
            df_count = '0;
          end else begin
            r.st = ST_START;
            df_left = len[LenW-1:0];
            df_window = '0;
            df_phase = (len == '0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end else begin
          r.st = ST_HDR;
        end
      end
      PH_PAYLOAD: begin
        r.st = ST_PAY;
        r.obyte = b;
        df_left = df_left - LenW'(1);
        if (df_left == '0) begin
          r.last = 1'b1;
          df_phase = PH_TRAILER;
          df_window = '0;
          df_count = '0;
        end
      end
      default: begin
        df_window = window_shift(df_window, b, df_big);
        df_count = df_count + 3'd1;
        if (df_count >= CntTypeDone) begin
          if (df_window == reg_sync) begin
            r.st = ST_SYNC;
          end else if (auto_mode && bytes_reversed(df_window) == reg_sync) begin
            df_big = ~df_big;
            r.st = ST_SYNC;
          end else begin
            r.st = ST_LOST;
          end
          df_phase = (r.st == ST_SYNC) ? PH_HEADER : PH_HUNT;
          df_window = '0;
          df_count = '0;
        end else begin
          r.st = ST_TRAIL;
        end
      end
    endcase
    r.ctype = df_type;
    r.clen = df_length;
    r.big = df_big;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    n_errors++;
    if (n_errors <= PrintedErrMax)
      $display("%0t ERROR %s: got %0h want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : scoreboard
    deframe_res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing pending", 32'(out_ch.status), '0);
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (out_ch.status !== want.st)
            report_mismatch("status", 32'(out_ch.status), 32'(want.st));
          if (out_ch.chunk_type !== want.ctype)
            report_mismatch("chunk_type", out_ch.chunk_type, want.ctype);
          if (out_ch.chunk_length !== want.clen)
            report_mismatch("chunk_length", 32'(out_ch.chunk_length), 32'(want.clen));
          if (out_ch.out_byte !== want.obyte)
            report_mismatch("out_byte", 32'(out_ch.out_byte), 32'(want.obyte));
          if (out_ch.last_payload !== want.last)
            report_mismatch("last_payload", 32'(out_ch.last_payload), 32'(want.last));
          if (out_ch.big_endian !== want.big)
            report_mismatch("big_endian", 32'(out_ch.big_endian), 32'(want.big));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          RegSyncWord:  reg_sync = cfg_ch.data;
          RegMaxLength: reg_max = cfg_ch.data[LenW-1:0];
          RegByteOrder: reg_mode = cfg_ch.data[ModeW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = deframe_byte(in_ch.in_byte);
        expected_q.push_back(want);
        seen_status[want.st]++;
        if (want.last) last_count++;
      end
    end
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin : receiver
    int hold_seen;
    int hold_left;
    if (rx_hold_req != hold_seen) begin
      hold_seen = rx_hold_req;
      hold_left = RxHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [WordW-1:0] w, input logic big);
    for (int i = 0; i < 4; i++)
      send_byte(big ? w[31-8*i -: 8] : w[8*i +: 8]);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [WordW-1:0] sync, input logic [LenW-1:0] max_len,
                          input logic [ModeW-1:0] mode);
    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    write_reg(RegSyncWord, sync);
    write_reg(RegMaxLength, {1'b0, max_len});
    write_reg(RegByteOrder, {30'd0, mode});
    cfg_ch.valid <= 1'b0;
    gen_sync = sync;
    gen_max = max_len;
    gen_mode = mode;
  endtask

  function automatic logic length_fits(input logic [WordW-1:0] len);
    return !len[31] && len <= {1'b0, gen_max} && len[1:0] == 2'd0;
  endfunction

  // mostly small aligned lengths; a few misaligned, negative or over the cap
  function automatic logic [WordW-1:0] pick_length();
    int cap;
    int r;
    r = $urandom_range(99);
    cap = (gen_max > LenW'(48)) ? 48 : int'(gen_max);
    if (r < 88) return 32'($urandom_range(cap / 4) * 4);
    if (r < 92) return 32'($urandom_range(cap / 4) * 4) | 32'($urandom_range(1, 3));
    if (r < 96) return {1'b1, 31'($urandom)};
    return ({1'b0, gen_max} + 32'd4) & ~32'd3;
  endfunction

  // runs of framed chunks with random content, broken up by noise,
  // byte-swapped trailers and damaged sync words
  task automatic send_frames(input int n_bytes);
    int               stop_at;
    int               n_chunks;
    int               r;
    logic [WordW-1:0] len;
    logic             ord;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      repeat ($urandom_range(3)) send_byte(8'($urandom));
      if (gen_mode == ModeBig) ord = 1'b1;
      else if (gen_mode == ModeLittle) ord = 1'b0;
      else ord = 1'($urandom_range(1));
      send_word(gen_sync, ord);
      n_chunks = $urandom_range(1, 5);
      for (int k = 0; k < n_chunks; k++) begin
        if (bytes_sent >= stop_at) break;
        send_word($urandom, ord);
        len = pick_length();
        send_word(len, ord);
        if (!length_fits(len)) break;
        repeat (len) send_byte(8'($urandom));
        r = $urandom_range(99);
        if (r < 80) begin
          send_word(gen_sync, ord);
        end else if (r < 90) begin
          ord = ~ord;
          send_word(gen_sync, ord);
          if (gen_mode == ModeBig || gen_mode == ModeLittle) break;
        end else begin
          send_word(gen_sync ^ (32'd1 << $urandom_range(31)), ord);
          break;
        end
      end
    end
  endtask

  // little-endian sync, zero-length chunk, swapped trailer flips order,
  // then a negative length drops back to hunting
  task automatic test_directed_frames();
    set_regs(32'h1122_3344, 31'd8, ModeAuto);
    send_word(32'h1122_3344, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h1122_3344, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_byte(8'hFF);
  endtask

  task automatic test_reset_settings();
    set_regs(SyncWordRst, MaxLenRst, ModeAuto);
    send_frames(160);
  endtask

  // only zero-length chunks pass
  task automatic test_zero_max_length();
    set_regs($urandom, 31'd0, ModeBig);
    send_frames(160);
  endtask

  task automatic test_little_with_rx_hold();
    set_regs($urandom, 31'd40, ModeLittle);
    rx_hold_req++;
    send_frames(160);
  endtask

  task automatic test_wide_settings_pause();
    set_regs(32'hFFFF_FFFF, 31'h7FFF_FFFF, ModeSpare);
    send_frames(80);
    wait_all_results();
    send_frames(80);
  endtask

  task automatic test_auto_full_rate();
    set_regs($urandom, 31'd16, ModeAuto);
    send_frames(160);
  endtask

  task automatic test_big_full_rate();
    set_regs($urandom, 31'd64, ModeBig);
    send_frames(160);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= RegSyncWord;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 17;
    rx_idle_pct = 81;
    test_directed_frames();
    test_reset_settings();
    test_zero_max_length();

    tx_idle_pct = 81;
    rx_idle_pct = 17;
    test_little_with_rx_hold();
    test_wide_settings_pause();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_auto_full_rate();
    test_big_full_rate();

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("result words never delivered", 32'(expected_q.size()), '0);

    $display("%0d stream bytes over 7 register settings, all byte order modes; %0d checked",
             bytes_sent, n_checked);
    $display("syncs %0d, chunk starts %0d, payload %0d (last %0d), bad lengths %0d, losses %0d",
             seen_status[ST_SYNC], seen_status[ST_START], seen_status[ST_PAY], last_count,
             seen_status[ST_BADLEN], seen_status[ST_LOST]);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
